### rtl/irc_tok_pkg.sv
// Shared types and constants for the IRC line tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package irc_tok_pkg;

  localparam int unsigned MAX_PARAMS = 15;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;

  localparam logic [2:0] ROLE_SEP      = 3'd0;
  localparam logic [2:0] ROLE_NICK     = 3'd1;
  localparam logic [2:0] ROLE_PREFIX   = 3'd2;
  localparam logic [2:0] ROLE_COMMAND  = 3'd3;
  localparam logic [2:0] ROLE_PARAM    = 3'd4;
  localparam logic [2:0] ROLE_TRAILING = 3'd5;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_VOID    = 2'd1;
  localparam logic [1:0] STATUS_DROPPED = 2'd2;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] role;
    logic [3:0] param_index;
    logic       token_start;
    logic       line_end;
    logic [1:0] line_status;
    logic [3:0] param_count;
    logic       trailing_present;
  } res_t;

endpackage
`default_nettype wire

### rtl/irc_tok_step.sv
// Per-byte tagging logic and line state of the IRC line tokenizer.
`timescale 1ns / 1ps
`default_nettype none
module irc_tok_step (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  output irc_tok_pkg::res_t      res
);

  typedef enum logic [2:0] {
    PH_LINE_START  = 3'd0,
    PH_NICK_FIRST  = 3'd1,
    PH_NICK        = 3'd2,
    PH_PREFIX_REST = 3'd3,
    PH_CMD_START   = 3'd4,
    PH_CMD         = 3'd5,
    PH_SKIP        = 3'd6,
    PH_TOKEN       = 3'd7
  } phase_t;

  localparam logic [3:0] LIMIT = 4'(irc_tok_pkg::MAX_PARAMS);

  phase_t     phase_r, phase_nxt, phase_mid;
  logic [3:0] params_seen_r, params_seen_nxt, params_mid;
  logic       overflow_r, overflow_nxt, overflow_mid;
  logic       trailing_r, trailing_nxt, trailing_mid;
  logic [2:0] role;
  logic [3:0] idx;
  logic       ts;
  logic       is_space, is_colon, is_bang;

  assign is_space = (data_byte == irc_tok_pkg::CH_SPACE);
  assign is_colon = (data_byte == irc_tok_pkg::CH_COLON);
  assign is_bang  = (data_byte == irc_tok_pkg::CH_BANG);

  always_comb begin
    phase_mid    = phase_r;
    params_mid   = params_seen_r;
    overflow_mid = overflow_r;
    trailing_mid = trailing_r;
    role         = irc_tok_pkg::ROLE_SEP;
    idx          = 4'd0;
    ts           = 1'b0;
    case (phase_r)
      PH_LINE_START: begin
        if (is_colon) begin
          phase_mid = PH_NICK_FIRST;
        end else if (is_space) begin
          phase_mid = PH_SKIP;
        end else begin
          role      = irc_tok_pkg::ROLE_COMMAND;
          ts        = 1'b1;
          phase_mid = PH_CMD;
        end
      end
      PH_NICK_FIRST, PH_NICK: begin
        if (is_space) begin
          phase_mid = PH_CMD_START;
        end else if (is_bang) begin
          role      = irc_tok_pkg::ROLE_PREFIX;
          phase_mid = PH_PREFIX_REST;
        end else begin
          role      = irc_tok_pkg::ROLE_NICK;
          ts        = (phase_r == PH_NICK_FIRST);
          phase_mid = PH_NICK;
        end
      end
      PH_PREFIX_REST: begin
        if (is_space) begin
          phase_mid = PH_CMD_START;
        end else begin
          role = irc_tok_pkg::ROLE_PREFIX;
        end
      end
      PH_CMD_START: begin
        if (is_space) begin
          phase_mid = PH_SKIP;
        end else begin
          role      = irc_tok_pkg::ROLE_COMMAND;
          ts        = 1'b1;
          phase_mid = PH_CMD;
        end
      end
      PH_CMD: begin
        if (is_space) begin
          phase_mid = PH_SKIP;
        end else begin
          role = irc_tok_pkg::ROLE_COMMAND;
        end
      end
      PH_SKIP: begin
        if (trailing_r) begin
          role      = irc_tok_pkg::ROLE_TRAILING;
          ts        = 1'b1;
          phase_mid = PH_TOKEN;
        end else if (is_space) begin
          phase_mid = PH_SKIP;
        end else if (is_colon) begin
          trailing_mid = 1'b1;
        end else if (params_seen_r < LIMIT) begin
          role       = irc_tok_pkg::ROLE_PARAM;
          idx        = params_seen_r;
          ts         = 1'b1;
          params_mid = params_seen_r + 4'd1;
          phase_mid  = PH_TOKEN;
        end else begin
          overflow_mid = 1'b1;
          phase_mid    = PH_TOKEN;
        end
      end
      default: begin
        if (trailing_r) begin
          role = irc_tok_pkg::ROLE_TRAILING;
        end else if (is_space) begin
          phase_mid = PH_SKIP;
        end else if (!overflow_r) begin
          role = irc_tok_pkg::ROLE_PARAM;
          idx  = params_seen_r - 4'd1;
        end
      end
    endcase
  end

  always_comb begin
    res.byte_out         = data_byte;
    res.role             = role;
    res.param_index      = idx;
    res.token_start      = ts;
    res.line_end         = last_byte;
    res.line_status      = irc_tok_pkg::STATUS_OK;
    res.param_count      = 4'd0;
    res.trailing_present = 1'b0;
    phase_nxt            = phase_mid;
    params_seen_nxt      = params_mid;
    overflow_nxt         = overflow_mid;
    trailing_nxt         = trailing_mid;
    if (last_byte) begin
      if (phase_mid == PH_NICK_FIRST || phase_mid == PH_NICK ||
          phase_mid == PH_PREFIX_REST) begin
        res.line_status = irc_tok_pkg::STATUS_VOID;
      end else begin
        res.line_status      = overflow_mid ? irc_tok_pkg::STATUS_DROPPED
                                            : irc_tok_pkg::STATUS_OK;
        res.param_count      = params_mid;
        res.trailing_present = trailing_mid;
      end
      phase_nxt       = PH_LINE_START;
      params_seen_nxt = 4'd0;
      overflow_nxt    = 1'b0;
      trailing_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LINE_START;
      params_seen_r <= 4'd0;
      overflow_r    <= 1'b0;
      trailing_r    <= 1'b0;
    end else if (advance) begin
      phase_r       <= phase_nxt;
      params_seen_r <= params_seen_nxt;
      overflow_r    <= overflow_nxt;
      trailing_r    <= trailing_nxt;
    end
  end

  a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last_byte |=> phase_r == PH_LINE_START && params_seen_r == 4'd0 &&
                             !overflow_r && !trailing_r)
    else $error("line state not cleared after last word");

  a_params_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    params_seen_r <= LIMIT)
    else $error("parameter count beyond limit");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |-> params_seen_r == LIMIT)
    else $error("overflow flagged before all parameters kept");

endmodule
`default_nettype wire

### rtl/irc_tok_out_reg.sv
// Result register with valid/ready handshake for the IRC line tokenizer.
`timescale 1ns / 1ps
`default_nettype none
module irc_tok_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load_valid,
  output logic                   load_ready,
  input  wire irc_tok_pkg::res_t load_res,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output irc_tok_pkg::res_t      out_res
);

  logic              valid_r;
  irc_tok_pkg::res_t res_r;

  assign load_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule
`default_nettype wire

### rtl/irc_line_tokenizer_unit.sv
// Top level of the IRC line tokenizer: input register, tagging logic, result register.
// A word moves from the input register via the tagging logic to the result register.
// Throughput: one word per cycle; in_ready drops only while the result register is
// full and out_ready is low.
// Reset: rst_n (synchronous, active low) empties both registers and returns the
// line state to line start with no parameters kept; no clearing pass follows.
`timescale 1ns / 1ps
`default_nettype none
module irc_line_tokenizer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte_out,
  output logic [2:0]      out_role,
  output logic [3:0]      out_param_index,
  output logic            out_token_start,
  output logic            out_line_end,
  output logic [1:0]      out_line_status,
  output logic [3:0]      out_param_count,
  output logic            out_trailing_present
);

  logic              s0_valid_r;
  logic [7:0]        s0_byte_r;
  logic              s0_last_r;
  logic              oreg_ready;
  logic              advance;
  irc_tok_pkg::res_t step_res;
  irc_tok_pkg::res_t out_res;

  assign advance  = s0_valid_r && oreg_ready;
  assign in_ready = !s0_valid_r || oreg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_byte_r <= in_data_byte;
      s0_last_r <= in_last_byte;
    end
  end

  irc_tok_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .data_byte (s0_byte_r),
    .last_byte (s0_last_r),
    .res       (step_res)
  );

  irc_tok_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s0_valid_r),
    .load_ready (oreg_ready),
    .load_res   (step_res),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign out_byte_out         = out_res.byte_out;
  assign out_role             = out_res.role;
  assign out_param_index      = out_res.param_index;
  assign out_token_start      = out_res.token_start;
  assign out_line_end         = out_res.line_end;
  assign out_line_status      = out_res.line_status;
  assign out_param_count      = out_res.param_count;
  assign out_trailing_present = out_res.trailing_present;

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_end |->
      out_line_status == irc_tok_pkg::STATUS_OK && out_param_count == 4'd0 &&
      !out_trailing_present)
    else $error("line status shown before last word");

  a_void_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_status == irc_tok_pkg::STATUS_VOID |->
      out_param_count == 4'd0 && !out_trailing_present)
    else $error("void line reports parameters or trailing");

  a_index_only_param: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_role != irc_tok_pkg::ROLE_PARAM |-> out_param_index == 4'd0)
    else $error("parameter index on non-parameter word");

  a_start_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_start |->
      out_role != irc_tok_pkg::ROLE_SEP && out_role != irc_tok_pkg::ROLE_PREFIX)
    else $error("token start on separator or prefix word");

endmodule
`default_nettype wire

### verif/tb_irc_line_tokenizer_unit.sv
// Testbench for irc_line_tokenizer_unit: directed table plus random lines.
`timescale 1ns / 1ps
module tb_irc_line_tokenizer_unit;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RAND_BYTES     = 1000;
  localparam int MID_PAUSE_AT   = 600;
  localparam int TAIL_ITEMS     = 150;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_LEN       = 80;

  typedef enum logic [2:0] {
    LS_START, LS_NICK_FIRST, LS_NICK, LS_PREFIX, LS_CMD_START, LS_CMD, LS_SKIP, LS_TOKEN
  } line_phase_t;

  typedef struct packed {
    logic [7:0]        b;
    logic              last;
    logic              typed;
    irc_tok_pkg::res_t want;
    logic              hold_first;
  } stim_t;

  localparam int DIR_N = 22;
  localparam stim_t DIR_ROWS [DIR_N] = '{
    '{8'h3A, 1'b1, 1'b1, '{8'h3A, irc_tok_pkg::ROLE_SEP, 4'd0, 1'b0, 1'b1,
                           irc_tok_pkg::STATUS_VOID, 4'd0, 1'b0}, 1'b0},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, irc_tok_pkg::ROLE_COMMAND, 4'd0, 1'b1, 1'b1,
                           irc_tok_pkg::STATUS_OK, 4'd0, 1'b0}, 1'b0},
    '{8'h00, 1'b1, 1'b1, '{8'h00, irc_tok_pkg::ROLE_COMMAND, 4'd0, 1'b1, 1'b1,
                           irc_tok_pkg::STATUS_OK, 4'd0, 1'b0}, 1'b0},
    '{8'h3A, 1'b0, 1'b1, '{8'h3A, irc_tok_pkg::ROLE_SEP, 4'd0, 1'b0, 1'b0,
                           irc_tok_pkg::STATUS_OK, 4'd0, 1'b0}, 1'b0},
    '{8'h21, 1'b0, 1'b0, '0, 1'b0},
    '{8'h61, 1'b0, 1'b0, '0, 1'b0},
    '{8'h20, 1'b0, 1'b0, '0, 1'b0},
    '{8'h62, 1'b1, 1'b0, '0, 1'b0},
    '{8'h3A, 1'b0, 1'b0, '0, 1'b0},
    '{8'h6E, 1'b0, 1'b0, '0, 1'b0},
    '{8'h20, 1'b0, 1'b0, '0, 1'b0},
    '{8'h78, 1'b1, 1'b0, '0, 1'b0},
    '{8'h20, 1'b0, 1'b0, '0, 1'b0},
    '{8'h20, 1'b0, 1'b0, '0, 1'b0},
    '{8'h3A, 1'b1, 1'b1, '{8'h3A, irc_tok_pkg::ROLE_SEP, 4'd0, 1'b0, 1'b1,
                           irc_tok_pkg::STATUS_OK, 4'd0, 1'b1}, 1'b0},
    '{8'h43, 1'b0, 1'b0, '0, 1'b0},
    '{8'h20, 1'b0, 1'b0, '0, 1'b0},
    '{8'h61, 1'b0, 1'b0, '0, 1'b0},
    '{8'h3A, 1'b0, 1'b0, '0, 1'b0},
    '{8'h20, 1'b0, 1'b0, '0, 1'b0},
    '{8'h3A, 1'b1, 1'b1, '{8'h3A, irc_tok_pkg::ROLE_SEP, 4'd0, 1'b0, 1'b1,
                           irc_tok_pkg::STATUS_OK, 4'd1, 1'b1}, 1'b0},
    '{8'h20, 1'b1, 1'b1, '{8'h20, irc_tok_pkg::ROLE_SEP, 4'd0, 1'b0, 1'b1,
                           irc_tok_pkg::STATUS_OK, 4'd0, 1'b0}, 1'b0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte_out;
  logic [2:0] out_role;
  logic [3:0] out_param_index;
  logic       out_token_start;
  logic       out_line_end;
  logic [1:0] out_line_status;
  logic [3:0] out_param_count;
  logic       out_trailing_present;

  irc_line_tokenizer_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_byte_out         (out_byte_out),
    .out_role             (out_role),
    .out_param_index      (out_param_index),
    .out_token_start      (out_token_start),
    .out_line_end         (out_line_end),
    .out_line_status      (out_line_status),
    .out_param_count      (out_param_count),
    .out_trailing_present (out_trailing_present)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  line_phase_t ls_phase = LS_START;
  logic [3:0]  kept_params = 4'd0;
  logic        dropping = 1'b0;
  logic        in_trailing = 1'b0;

  stim_t             byte_feed [$];
  irc_tok_pkg::res_t pending_tags [$];
  logic [7:0]        line_buf [$];
  stim_t             cur_item = '0;
  int                rand_bytes = 0;
  bit                pause_next = 1'b0;
  int                err_cnt = 0;
  int                idle_cycles = 0;
  int                acc_cnt = 0;
  bit                stim_done = 1'b0;
  bit                tail_part = 1'b0;

  int          tx_gap = 0;
  int          tx_calm = 0;
  int          rx_stall = 0;
  int          rx_calm = 0;
  int          hold_cnt = 0;
  bit          hold_done = 1'b0;

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  task automatic put_char(input logic [7:0] c);
    line_buf = {line_buf, c};
  endtask

  task automatic tag_byte(input logic [7:0] b, input logic last,
                          output irc_tok_pkg::res_t r);
    r = '0;
    r.byte_out = b;
    r.role = irc_tok_pkg::ROLE_SEP;
    r.line_end = last;
    case (ls_phase)
      LS_START: begin
        if (b == irc_tok_pkg::CH_COLON) ls_phase = LS_NICK_FIRST;
        else if (b == irc_tok_pkg::CH_SPACE) ls_phase = LS_SKIP;
        else begin
          r.role = irc_tok_pkg::ROLE_COMMAND;
          r.token_start = 1'b1;
          ls_phase = LS_CMD;
        end
      end
      LS_NICK_FIRST, LS_NICK: begin
        if (b == irc_tok_pkg::CH_SPACE) ls_phase = LS_CMD_START;
        else if (b == irc_tok_pkg::CH_BANG) begin
          r.role = irc_tok_pkg::ROLE_PREFIX;
          ls_phase = LS_PREFIX;
        end else begin
          r.role = irc_tok_pkg::ROLE_NICK;
          r.token_start = (ls_phase == LS_NICK_FIRST);
          ls_phase = LS_NICK;
        end
      end
      LS_PREFIX: begin
        if (b == irc_tok_pkg::CH_SPACE) ls_phase = LS_CMD_START;
        else r.role = irc_tok_pkg::ROLE_PREFIX;
      end
      LS_CMD_START: begin
        if (b == irc_tok_pkg::CH_SPACE) ls_phase = LS_SKIP;
        else begin
          r.role = irc_tok_pkg::ROLE_COMMAND;
          r.token_start = 1'b1;
          ls_phase = LS_CMD;
        end
      end
      LS_CMD: begin
        if (b == irc_tok_pkg::CH_SPACE) ls_phase = LS_SKIP;
        else r.role = irc_tok_pkg::ROLE_COMMAND;
      end
      LS_SKIP: begin
        if (in_trailing) begin
          r.role = irc_tok_pkg::ROLE_TRAILING;
          r.token_start = 1'b1;
          ls_phase = LS_TOKEN;
        end else if (b == irc_tok_pkg::CH_SPACE) begin
        end else if (b == irc_tok_pkg::CH_COLON) begin
          in_trailing = 1'b1;
        end else if (kept_params < irc_tok_pkg::MAX_PARAMS) begin
          r.role = irc_tok_pkg::ROLE_PARAM;
          r.param_index = kept_params;
          r.token_start = 1'b1;
          kept_params = kept_params + 4'd1;
          ls_phase = LS_TOKEN;
        end else begin
          dropping = 1'b1;
          ls_phase = LS_TOKEN;
        end
      end
      default: begin
        if (in_trailing) r.role = irc_tok_pkg::ROLE_TRAILING;
        else if (b == irc_tok_pkg::CH_SPACE) ls_phase = LS_SKIP;
        else if (!dropping) begin
          r.role = irc_tok_pkg::ROLE_PARAM;
          r.param_index = kept_params - 4'd1;
        end
      end
    endcase
    if (last) begin
      if (ls_phase == LS_NICK_FIRST || ls_phase == LS_NICK || ls_phase == LS_PREFIX) begin
        r.line_status = irc_tok_pkg::STATUS_VOID;
      end else begin
        r.line_status = dropping ? irc_tok_pkg::STATUS_DROPPED : irc_tok_pkg::STATUS_OK;
        r.param_count = kept_params;
        r.trailing_present = in_trailing;
      end
      ls_phase = LS_START;
      kept_params = 4'd0;
      dropping = 1'b0;
      in_trailing = 1'b0;
    end
  endtask

  function automatic logic [7:0] word_char(input bit first);
    logic [7:0] c;
    c = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(33, 126)) : 8'($urandom_range(0, 255));
    while (c == irc_tok_pkg::CH_SPACE || (first && c == irc_tok_pkg::CH_COLON))
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 7))
      0, 1: return irc_tok_pkg::CH_COLON;
      2, 3: return irc_tok_pkg::CH_SPACE;
      4: return irc_tok_pkg::CH_BANG;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic feed_line();
    stim_t s;
    foreach (line_buf[k]) begin
      s = '0;
      s.b = line_buf[k];
      s.last = (k == line_buf.size() - 1);
      s.hold_first = pause_next && (k == 0);
      byte_feed = {byte_feed, s};
    end
    pause_next = 1'b0;
    rand_bytes += line_buf.size();
    line_buf.delete();
  endtask

  task automatic gen_line();
    int kind;
    int n;
    int np;
    bit big;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      if ($urandom_range(0, 1) != 0) begin
        put_char(irc_tok_pkg::CH_COLON);
        n = $urandom_range(0, 4);
        repeat (n) put_char(word_char(1'b0));
        if ($urandom_range(0, 1) != 0) begin
          put_char(irc_tok_pkg::CH_BANG);
          n = $urandom_range(0, 6);
          repeat (n) put_char(word_char(1'b0));
        end
        put_char(irc_tok_pkg::CH_SPACE);
      end
      put_char(word_char(1'b1));
      n = $urandom_range(0, 4);
      repeat (n) put_char(word_char(1'b0));
      big = ($urandom_range(0, 5) == 0);
      np = big ? $urandom_range(14, 17) : $urandom_range(0, 4);
      repeat (np) begin
        n = $urandom_range(1, 3);
        repeat (n) put_char(irc_tok_pkg::CH_SPACE);
        put_char(word_char(1'b1));
        n = big ? 0 : $urandom_range(0, 2);
        repeat (n) put_char(word_char(1'b0));
      end
      if ($urandom_range(0, 1) != 0) begin
        put_char(irc_tok_pkg::CH_SPACE);
        put_char(irc_tok_pkg::CH_COLON);
        n = $urandom_range(0, 8);
        repeat (n) put_char(noise_char());
      end
    end else if (kind < 72) begin
      put_char(irc_tok_pkg::CH_COLON);
      n = $urandom_range(0, 5);
      repeat (n) put_char(word_char(1'b0));
      if ($urandom_range(0, 1) != 0) begin
        put_char(irc_tok_pkg::CH_BANG);
        n = $urandom_range(0, 3);
        repeat (n) put_char(word_char(1'b0));
      end
    end else if (kind < 80) begin
      put_char(word_char(1'b1));
      n = $urandom_range(1, 3);
      repeat (n) put_char(irc_tok_pkg::CH_SPACE);
      if ($urandom_range(0, 1) != 0) put_char(irc_tok_pkg::CH_COLON);
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) put_char(noise_char());
    end
    feed_line();
  endtask

  always @(posedge clk) begin : drive_in
    bit fire;
    fire = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !fire) begin
    end else if (tx_gap != 0) begin
      tx_gap <= tx_gap - 1;
      in_valid <= 1'b0;
    end else if (byte_feed.size() == 0) begin
      in_valid <= 1'b0;
      stim_done <= 1'b1;
    end else if (byte_feed[0].hold_first && (in_valid || pending_tags.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      cur_item <= byte_feed[0];
      in_data_byte <= byte_feed[0].b;
      in_last_byte <= byte_feed[0].last;
      in_valid <= 1'b1;
      void'(byte_feed.pop_front());
      if (byte_feed.size() < TAIL_ITEMS) tail_part <= 1'b1;
      if (tx_calm != 0) begin
        tx_calm <= tx_calm - 1;
      end else if (!tail_part) begin
        case ($urandom_range(0, 19))
          0, 1, 2: tx_gap <= $urandom_range(1, 14);
          3: tx_calm <= $urandom_range(20, 80);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin : drive_out
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && acc_cnt >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (tail_part) begin
      out_ready <= 1'b1;
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      out_ready <= 1'b0;
    end else if (rx_calm != 0) begin
      rx_calm <= rx_calm - 1;
      out_ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          out_ready <= 1'b0;
          rx_stall <= $urandom_range(0, 13);
        end
        3: begin
          out_ready <= 1'b1;
          rx_calm <= $urandom_range(20, 80);
        end
        default: out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin : watch
    irc_tok_pkg::res_t pred;
    irc_tok_pkg::res_t want;
    irc_tok_pkg::res_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tag_byte(in_data_byte, in_last_byte, pred);
        pending_tags = {pending_tags, (cur_item.typed ? cur_item.want : pred)};
        acc_cnt <= acc_cnt + 1;
      end
      if (out_valid && out_ready) begin
        if (pending_tags.size() == 0) begin
          note_mismatch("word with nothing pending, byte", out_byte_out, -1);
        end else begin
          want = pending_tags.pop_front();
          got = '{out_byte_out, out_role, out_param_index, out_token_start, out_line_end,
                  out_line_status, out_param_count, out_trailing_present};
          if (got.byte_out != want.byte_out)
            note_mismatch("byte_out", got.byte_out, want.byte_out);
          if (got.role != want.role) note_mismatch("role", got.role, want.role);
          if (got.param_index != want.param_index)
            note_mismatch("param_index", got.param_index, want.param_index);
          if (got.token_start != want.token_start)
            note_mismatch("token_start", got.token_start, want.token_start);
          if (got.line_end != want.line_end)
            note_mismatch("line_end", got.line_end, want.line_end);
          if (got.line_status != want.line_status)
            note_mismatch("line_status", got.line_status, want.line_status);
          if (got.param_count != want.param_count)
            note_mismatch("param_count", got.param_count, want.param_count);
          if (got.trailing_present != want.trailing_present)
            note_mismatch("trailing_present", got.trailing_present, want.trailing_present);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run
    bit mid_pause_done;
    mid_pause_done = 1'b0;
    for (int i = 0; i < DIR_N; i++) byte_feed = {byte_feed, DIR_ROWS[i]};
    pause_next = 1'b1;
    while (rand_bytes < RAND_BYTES) begin
      if (!mid_pause_done && rand_bytes >= MID_PAUSE_AT) begin
        pause_next = 1'b1;
        mid_pause_done = 1'b1;
      end
      gen_line();
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_done && pending_tags.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL irc_line_tokenizer_unit");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (pending_tags.size() != 0) note_mismatch("words never seen", pending_tags.size(), 0);
      if (err_cnt == 0) begin
        $display("PASS irc_line_tokenizer_unit");
      end else begin
        $display("FAIL irc_line_tokenizer_unit");
      end
    end
    $finish;
  end

endmodule
